FILE: sv/genetic_parent_selector_unit_assert.svh
// ----------------------------------------------------------------------------
// Genetic parent selector assertion macros
// Concurrent property wrappers used by the selector top level.
// ----------------------------------------------------------------------------
`ifndef GENETIC_PARENT_SELECTOR_UNIT_ASSERT_SVH
`define GENETIC_PARENT_SELECTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gps assertion failed");

// next-cycle implication, disabled during reset
`define GPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gps assertion failed");

`endif

FILE: sv/gps_pkg.sv
// ----------------------------------------------------------------------------
// Genetic parent selector package
// Shared codes, controller states and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gps_pkg;

  localparam int CNT_W    = 9;
  localparam int CFG_W    = 9;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 8;
  localparam int TDATA_W  = 136;

  typedef enum logic [1:0] {
    FUNC_CLEAR      = 2'd0,
    FUNC_LOAD       = 2'd1,
    FUNC_ROULETTE   = 2'd2,
    FUNC_TOURNAMENT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    VERDICT_COPY   = 2'd0,
    VERDICT_REINIT = 2'd1,
    VERDICT_KEEP   = 2'd2,
    VERDICT_DONE   = 2'd3
  } verdict_t;

  typedef enum logic {
    REG_POP_SIZE   = 1'b0,
    REG_COPY_CUTOFF = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROU,
    ST_TMUL,
    ST_TRDA,
    ST_TRDB,
    ST_TCMP,
    ST_JRD,
    ST_JWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;    // latch the accepted request
    logic upd;        // clear or load table update
    logic scan_init;  // restart roulette scan
    logic scan;       // advance roulette scan
    logic sel_scan;   // take scan hit as chosen member
    logic res_miss;   // roulette found nothing
    logic tmul;       // tournament index multiply
    logic rd_b;       // fitness read address: second contender
    logic cap_a;      // hold first contender fitness
    logic tcmp;       // pick tournament winner
    logic judge;      // copy count check and update
    logic out_load;   // move result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  rou_hit;
    logic  rou_miss;
  } dp_status_t;

endpackage

FILE: sv/gps_datapath.sv
// ----------------------------------------------------------------------------
// Genetic parent selector datapath
// Member tables, roulette scan, tournament index math and copy count update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_datapath #(
  parameter int MAX_POPULATION = 256,
  parameter int FITNESS_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gps_pkg::ctrl_cmd_t          cmd,
  output gps_pkg::dp_status_t         status,
  input  logic [1:0]                  in_func,
  input  logic [gps_pkg::TDATA_W-1:0] in_data,
  input  logic [gps_pkg::CFG_W-1:0]   population_size,
  input  logic [gps_pkg::CFG_W-1:0]   copy_cutoff,
  output logic [gps_pkg::IDX_W-1:0]   parent_index,
  output gps_pkg::verdict_t           verdict
);

  localparam int AW   = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
  localparam int SW   = $clog2(MAX_POPULATION + 1);
  localparam int CMPW = (SW > gps_pkg::CFG_W) ? SW : gps_pkg::CFG_W;
  localparam int PW   = gps_pkg::CFG_W + gps_pkg::DATA_W;

  // captured request
  gps_pkg::func_t               func_q;
  logic [gps_pkg::IDX_W-1:0]    entry_q;
  logic [gps_pkg::DATA_W-1:0]   fit_in_q;
  logic [gps_pkg::DATA_W-1:0]   share_in_q;
  logic [gps_pkg::DATA_W-1:0]   r1_q;
  logic [gps_pkg::DATA_W-1:0]   r2_q;

  // tables
  logic [FITNESS_WIDTH-1:0]     fit_mem [MAX_POPULATION];
  logic [gps_pkg::DATA_W-1:0]   share_mem [MAX_POPULATION];
  logic [gps_pkg::CNT_W-1:0]    cnt_mem [MAX_POPULATION];
  logic [MAX_POPULATION-1:0]    cnt_vld;

  logic [FITNESS_WIDTH-1:0]     fit_rd;
  logic [FITNESS_WIDTH-1:0]     fit_a;
  logic [gps_pkg::DATA_W-1:0]   share_rd;
  logic [gps_pkg::CNT_W-1:0]    cnt_rd;

  logic [SW-1:0]                issue;
  logic                         pend;
  logic [AW-1:0]                pend_idx;

  logic [PW-1:0]                prod_a;
  logic [PW-1:0]                prod_b;
  logic [AW-1:0]                idx_a;
  logic [AW-1:0]                idx_b;
  logic [AW-1:0]                fit_addr;
  logic [AW-1:0]                sel_idx;

  logic [gps_pkg::IDX_W-1:0]    res_idx;
  gps_pkg::verdict_t            res_verdict;

  logic [gps_pkg::CFG_W-1:0]    n_eff;
  logic                         issue_lt_n;
  logic [63:0]                  fit_ext;
  logic [FITNESS_WIDTH-1:0]     fit_store;
  logic                         entry_ok;
  logic [gps_pkg::CNT_W-1:0]    cnt_eff;
  logic [gps_pkg::CFG_W-1:0]    ia_raw;
  logic [gps_pkg::CFG_W-1:0]    ib_raw;

  always_comb begin
    if (32'(population_size) > 32'(MAX_POPULATION)) begin
      n_eff = gps_pkg::CFG_W'(MAX_POPULATION);
    end else begin
      n_eff = population_size;
    end
  end

  assign issue_lt_n = CMPW'(issue) < CMPW'(n_eff);
  assign fit_ext    = {{32{fit_in_q[gps_pkg::DATA_W-1]}}, fit_in_q};
  assign fit_store  = fit_ext[FITNESS_WIDTH-1:0];
  assign entry_ok   = 32'(entry_q) < 32'(MAX_POPULATION);
  assign cnt_eff    = cnt_vld[sel_idx] ? cnt_rd : '0;

  // tournament index: floor(n * draw / 2^32), clamped to the table
  assign ia_raw = prod_a[PW-1:gps_pkg::DATA_W];
  assign ib_raw = prod_b[PW-1:gps_pkg::DATA_W];
  assign idx_a  = (32'(ia_raw) >= 32'(MAX_POPULATION)) ? AW'(MAX_POPULATION - 1) : AW'(ia_raw);
  assign idx_b  = (32'(ib_raw) >= 32'(MAX_POPULATION)) ? AW'(MAX_POPULATION - 1) : AW'(ib_raw);
  assign fit_addr = cmd.rd_b ? idx_b : idx_a;

  assign status.func     = func_q;
  assign status.rou_hit  = pend && (share_rd > r1_q);
  assign status.rou_miss = !pend && !issue_lt_n;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= gps_pkg::func_t'(in_func);
      entry_q    <= in_data[7:0];
      fit_in_q   <= in_data[39:8];
      share_in_q <= in_data[71:40];
      r1_q       <= in_data[103:72];
      r2_q       <= in_data[135:104];
    end
  end

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.upd && func_q == gps_pkg::FUNC_LOAD && entry_ok) begin
      fit_mem[AW'(entry_q)]   <= fit_store;
      share_mem[AW'(entry_q)] <= share_in_q;
    end
    if (cmd.judge && cnt_eff < copy_cutoff) begin
      cnt_mem[sel_idx] <= cnt_eff + 1'b1;
    end
    fit_rd   <= fit_mem[fit_addr];
    share_rd <= share_mem[issue[AW-1:0]];
    cnt_rd   <= cnt_mem[sel_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (cmd.upd && func_q == gps_pkg::FUNC_CLEAR) begin
      cnt_vld <= '0;
    end else if (cmd.judge && cnt_eff < copy_cutoff) begin
      cnt_vld[sel_idx] <= 1'b1;
    end
  end

  // roulette scan: one share read issued per cycle, compared on the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= '0;
      pend  <= 1'b0;
    end else if (cmd.scan_init) begin
      issue <= '0;
      pend  <= 1'b0;
    end else if (cmd.scan) begin
      if (issue_lt_n) begin
        issue <= issue + 1'b1;
        pend  <= 1'b1;
      end else begin
        pend  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pend_idx <= issue[AW-1:0];
    end
    if (cmd.tmul) begin
      prod_a <= PW'(n_eff) * PW'(r1_q);
      prod_b <= PW'(n_eff) * PW'(r2_q);
    end
    if (cmd.cap_a) begin
      fit_a <= fit_rd;
    end
    if (cmd.sel_scan) begin
      sel_idx <= pend_idx;
    end else if (cmd.tcmp) begin
      // ties go to the second contender
      sel_idx <= ($signed(fit_a) > $signed(fit_rd)) ? idx_a : idx_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      res_idx     <= '0;
      res_verdict <= gps_pkg::VERDICT_DONE;
    end else if (cmd.res_miss) begin
      res_idx     <= '0;
      res_verdict <= gps_pkg::VERDICT_KEEP;
    end else if (cmd.judge) begin
      res_idx     <= gps_pkg::IDX_W'(sel_idx);
      res_verdict <= (cnt_eff >= copy_cutoff) ? gps_pkg::VERDICT_REINIT
                                              : gps_pkg::VERDICT_COPY;
    end
    if (cmd.out_load) begin
      parent_index <= res_idx;
      verdict      <= res_verdict;
    end
  end

endmodule

FILE: sv/gps_ctrl.sv
// ----------------------------------------------------------------------------
// Genetic parent selector controller
// Sequences one request at a time and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  gps_pkg::dp_status_t  status,
  output gps_pkg::ctrl_cmd_t   cmd
);

  gps_pkg::state_t state;
  gps_pkg::state_t state_next;

  assign s_tready = (state == gps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gps_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      gps_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = gps_pkg::ST_DISPATCH;
        end
      end
      gps_pkg::ST_DISPATCH: begin
        case (status.func)
          gps_pkg::FUNC_ROULETTE: begin
            cmd.scan_init = 1'b1;
            state_next    = gps_pkg::ST_ROU;
          end
          gps_pkg::FUNC_TOURNAMENT: begin
            state_next = gps_pkg::ST_TMUL;
          end
          default: begin
            cmd.upd    = 1'b1;
            state_next = gps_pkg::ST_DONE;
          end
        endcase
      end
      gps_pkg::ST_ROU: begin
        cmd.scan = 1'b1;
        if (status.rou_hit) begin
          cmd.sel_scan = 1'b1;
          state_next   = gps_pkg::ST_JRD;
        end else if (status.rou_miss) begin
          cmd.res_miss = 1'b1;
          state_next   = gps_pkg::ST_DONE;
        end
      end
      gps_pkg::ST_TMUL: begin
        cmd.tmul   = 1'b1;
        state_next = gps_pkg::ST_TRDA;
      end
      gps_pkg::ST_TRDA: begin
        state_next = gps_pkg::ST_TRDB;
      end
      gps_pkg::ST_TRDB: begin
        cmd.rd_b   = 1'b1;
        cmd.cap_a  = 1'b1;
        state_next = gps_pkg::ST_TCMP;
      end
      gps_pkg::ST_TCMP: begin
        cmd.tcmp   = 1'b1;
        state_next = gps_pkg::ST_JRD;
      end
      gps_pkg::ST_JRD: begin
        state_next = gps_pkg::ST_JWR;
      end
      gps_pkg::ST_JWR: begin
        cmd.judge  = 1'b1;
        state_next = gps_pkg::ST_DONE;
      end
      gps_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = gps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/genetic_parent_selector_unit.sv
// ----------------------------------------------------------------------------
// Genetic parent selector unit
// Roulette and tournament parent selection with per-member copy limits.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_ stream (tuser = func), one result per
// request leaves on the m_ stream (tdata = parent index, tuser = verdict).
// Clear and load requests update the tables and answer "update done".
// A roulette pick scans the share table from member 0, one entry per cycle
// through the share memory read port, and stops at the first share above
// the draw; a tournament pick takes two index multiplies, two fitness reads
// and a compare. Both then read the chosen member's copy count and raise it
// while it is below copy_cutoff. One request is in flight at a time; the
// next is taken as soon as the result sits in the output register.
// Reset empties the pipeline, zeroes all copy counts through per-member
// valid bits and sets population_size and copy_cutoff to 256; fitness and
// share entries hold nothing until loaded. If the receiver stalls, the
// result is held and the next request waits in its final step.
// The user writes configuration over APB only while no request is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module genetic_parent_selector_unit #(
  parameter int MAX_POPULATION = 256,
  parameter int FITNESS_WIDTH  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] entry_index, [39:8] fitness_value, [71:40] cumulative_share,
  // [103:72] random_first, [135:104] random_second
  input  logic [135:0] s_tdata,
  // [1:0] func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] parent_index
  output logic [7:0]   m_tdata,
  // [1:0] verdict
  output logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  `include "genetic_parent_selector_unit_assert.svh"

  logic [gps_pkg::CFG_W-1:0] population_size;
  logic [gps_pkg::CFG_W-1:0] copy_cutoff;
  gps_pkg::reg_idx_t         reg_sel;
  gps_pkg::ctrl_cmd_t        cmd;
  gps_pkg::dp_status_t       status;
  gps_pkg::verdict_t         verdict;

  assign pready  = 1'b1;
  assign reg_sel = gps_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      population_size <= gps_pkg::CFG_W'(256);
      copy_cutoff     <= gps_pkg::CFG_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        gps_pkg::REG_POP_SIZE:    population_size <= pwdata[gps_pkg::CFG_W-1:0];
        gps_pkg::REG_COPY_CUTOFF: copy_cutoff     <= pwdata[gps_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      gps_pkg::REG_POP_SIZE:    prdata = 32'(population_size);
      gps_pkg::REG_COPY_CUTOFF: prdata = 32'(copy_cutoff);
      default:                  prdata = '0;
    endcase
  end

  gps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gps_datapath #(
    .MAX_POPULATION (MAX_POPULATION),
    .FITNESS_WIDTH  (FITNESS_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_func         (s_tuser),
    .in_data         (s_tdata),
    .population_size (population_size),
    .copy_cutoff     (copy_cutoff),
    .parent_index    (m_tdata),
    .verdict         (verdict)
  );

  assign m_tuser = verdict;

  // a request in flight blocks the input side
  `GPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  // no member chosen means index zero
  `GPS_ASSERT_NOW(a_keep_idx_zero, clk, rst, m_tvalid && m_tuser == gps_pkg::VERDICT_KEEP, m_tdata == 8'd0)
  `GPS_ASSERT_NOW(a_done_idx_zero, clk, rst, m_tvalid && m_tuser == gps_pkg::VERDICT_DONE, m_tdata == 8'd0)

endmodule
